[src/mandelbrot_escape_time_assert.svh]
// assertion macros for the mandelbrot escape-time block
// used by mandelbrot_escape_time.sv, no other dependencies
`ifndef MANDELBROT_ESCAPE_TIME_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_ASSERT_SVH
`ifndef SYNTHESIS
`define MET_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MET_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MET_ASSERT(lbl, clk, rst_n, prop, msg)
`define MET_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[src/met_pkg.sv]
// types, constants and fixed-point helpers for the mandelbrot escape-time block
// no dependencies
`timescale 1ns / 1ps

package met_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int REG_FRAC   = 28;
    localparam int WORD_W     = FRAC_BITS + 4;
    localparam int PROD_W     = 2 * WORD_W;
    localparam int IMAGE_SIZE = 1024;
    localparam int IDX_W      = 10;
    localparam int CNT_W      = 12;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;
    localparam int STEP_W     = 31;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [WORD_W:0]   word_ext_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;
    typedef logic [1:0]               reg_idx_t;

    localparam reg_idx_t REG_X_ORIGIN   = 2'd0;
    localparam reg_idx_t REG_Y_ORIGIN   = 2'd1;
    localparam reg_idx_t REG_PIXEL_STEP = 2'd2;
    localparam reg_idx_t REG_MAX_ITER   = 2'd3;

    localparam logic [31:0]       X_ORIGIN_RST   = 32'hE000_0000;
    localparam logic [31:0]       Y_ORIGIN_RST   = 32'hE000_0000;
    localparam logic [STEP_W-1:0] PIXEL_STEP_RST = STEP_W'(1048576);
    localparam cnt_t              MAX_ITER_RST   = CNT_W'(255);

    localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam word_ext_t FOUR = word_ext_t'((WORD_W+1)'(1) << (FRAC_BITS + 2));

    // register format to internal word, right shift rounds toward minus infinity
    function automatic word_t to_word(input logic signed [31:0] v);
        logic signed [63:0] wide;
        wide = 64'(v);
        if (FRAC_BITS >= REG_FRAC)
            wide = wide <<< (FRAC_BITS - REG_FRAC);
        else
            wide = wide >>> (REG_FRAC - FRAC_BITS);
        return wide[WORD_W-1:0];
    endfunction

    function automatic word_t sat_add(input word_t a, input word_t b);
        word_ext_t s;
        s = word_ext_t'(a) + word_ext_t'(b);
        if (s[WORD_W] != s[WORD_W-1])
            return s[WORD_W] ? WORD_MIN : WORD_MAX;
        return s[WORD_W-1:0];
    endfunction

    // floor(p / 2^sh) saturated to the word range
    function automatic word_t sat_shift(input prod_t p, input int unsigned sh);
        prod_t q;
        q = p >>> sh;
        if ((&q[PROD_W-1:WORD_W-1]) || !(|q[PROD_W-1:WORD_W-1]))
            return q[WORD_W-1:0];
        return q[PROD_W-1] ? WORD_MIN : WORD_MAX;
    endfunction

    function automatic idx_t clamp_idx(input idx_t v);
        if (32'(v) > 32'(IMAGE_SIZE - 1))
            return idx_t'(IMAGE_SIZE - 1);
        return v;
    endfunction

endpackage

[src/mandelbrot_escape_time.sv]
// mandelbrot escape-time unit: one shared multiplier under a small sequencer
// depends on met_pkg and mandelbrot_escape_time_assert.svh
//
// channel   | handshake                  | payload
// ----------+----------------------------+--------------------------------
// item      | item_valid / item_ready    | column, row
// result    | res_valid / res_ready      | iter_count, inside_res
// config    | psel, penable, pwrite      | paddr, pwdata, prdata (pready=1)
//
// the pixel is mapped to c in states CR, CI and CIW, then each iteration runs
// MRI, UPD, MRR, MII and TST (three products through the single multiplier),
// then DONE loads the result register.
// reset is asynchronous, active low, and restores the register defaults.
// one item is in flight at a time; a held result blocks only the next finish.
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_assert.svh"

module mandelbrot_escape_time
    import met_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic [IDX_W-1:0]  column,
    input  logic [IDX_W-1:0]  row,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [CNT_W-1:0]  iter_count,
    output logic              inside_res
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CR   = 4'd1;
    localparam logic [3:0] S_CI   = 4'd2;
    localparam logic [3:0] S_CIW  = 4'd3;
    localparam logic [3:0] S_MRI  = 4'd4;
    localparam logic [3:0] S_UPD  = 4'd5;
    localparam logic [3:0] S_MRR  = 4'd6;
    localparam logic [3:0] S_MII  = 4'd7;
    localparam logic [3:0] S_TST  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [31:0]       x_origin_reg, y_origin_reg;
    logic [STEP_W-1:0] pixel_step_reg;
    cnt_t              max_iter_reg;
    logic              res_valid_reg, res_valid_next;
    cnt_t              res_count_reg, res_count_next;
    logic              res_inside_reg, res_inside_next;

    idx_t  col_reg, col_next;
    idx_t  row_reg, row_next;
    word_t cr_reg, cr_next;
    word_t ci_reg, ci_next;
    word_t zr_reg, zr_next;
    word_t zi_reg, zi_next;
    word_t r2_reg, r2_next;
    word_t i2_reg, i2_next;
    cnt_t  n_reg, n_next;
    logic  inside_reg, inside_next;
    prod_t p_reg, p_next;

    word_t     mul_a, mul_b;
    word_t     step_w;
    word_t     i2_now;
    word_ext_t four_minus_r2;
    logic      escape;
    cnt_t      n_plus;
    logic      cfg_wr;
    reg_idx_t  cfg_idx;

    assign cfg_wr     = psel && penable && pwrite;
    assign cfg_idx    = paddr[ADDR_W-1:2];
    assign pready     = 1'b1;
    assign item_ready = (state_reg == S_IDLE);
    assign res_valid  = res_valid_reg;
    assign iter_count = res_count_reg;
    assign inside_res = res_inside_reg;

    assign step_w        = to_word(signed'({1'b0, pixel_step_reg}));
    assign i2_now        = sat_shift(p_reg, FRAC_BITS);
    assign four_minus_r2 = FOUR - word_ext_t'(r2_reg);
    assign escape        = (word_ext_t'(r2_reg) > FOUR) || (word_ext_t'(i2_now) > four_minus_r2);
    assign n_plus        = n_reg + CNT_W'(1);

    always_comb
    begin
        case (cfg_idx)
            REG_X_ORIGIN:   prdata = x_origin_reg;
            REG_Y_ORIGIN:   prdata = y_origin_reg;
            REG_PIXEL_STEP: prdata = {1'b0, pixel_step_reg};
            REG_MAX_ITER:   prdata = {{(DATA_W-CNT_W){1'b0}}, max_iter_reg};
            default:        prdata = '0;
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_CR:
            begin
                mul_a = step_w;
                mul_b = {{(WORD_W-IDX_W){1'b0}}, col_reg};
            end
            S_CI:
            begin
                mul_a = step_w;
                mul_b = {{(WORD_W-IDX_W){1'b0}}, row_reg};
            end
            S_MRR:
            begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            S_MII:
            begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            default:
            begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
        endcase
        p_next = mul_a * mul_b;
    end

    always_comb
    begin
        state_next      = state_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        cr_next         = cr_reg;
        ci_next         = ci_reg;
        zr_next         = zr_reg;
        zi_next         = zi_reg;
        r2_next         = r2_reg;
        i2_next         = i2_reg;
        n_next          = n_reg;
        inside_next     = inside_reg;
        res_count_next  = res_count_reg;
        res_inside_next = res_inside_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    col_next   = clamp_idx(column);
                    row_next   = clamp_idx(row);
                    state_next = S_CR;
                end
            end
            S_CR:
            begin
                state_next = S_CI;
            end
            S_CI:
            begin
                cr_next    = sat_add(to_word(signed'(x_origin_reg)), sat_shift(p_reg, 0));
                state_next = S_CIW;
            end
            S_CIW:
            begin
                ci_next = sat_add(to_word(signed'(y_origin_reg)), sat_shift(p_reg, 0));
                zr_next = '0;
                zi_next = '0;
                r2_next = '0;
                i2_next = '0;
                n_next  = '0;
                if (max_iter_reg == '0)
                begin
                    inside_next = 1'b1;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_MRI;
                end
            end
            S_MRI:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                zr_next    = sat_add(sat_add(r2_reg, -i2_reg), cr_reg);
                zi_next    = sat_add(sat_shift(p_reg, FRAC_BITS - 1), ci_reg);
                state_next = S_MRR;
            end
            S_MRR:
            begin
                state_next = S_MII;
            end
            S_MII:
            begin
                r2_next    = sat_shift(p_reg, FRAC_BITS);
                state_next = S_TST;
            end
            S_TST:
            begin
                i2_next = i2_now;
                if (escape)
                begin
                    inside_next = 1'b0;
                    state_next  = S_DONE;
                end
                else
                begin
                    n_next = n_plus;
                    if (n_plus >= max_iter_reg)
                    begin
                        inside_next = 1'b1;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_MRI;
                    end
                end
            end
            S_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next  = 1'b1;
                    res_count_next  = n_reg;
                    res_inside_next = inside_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            res_valid_reg  <= 1'b0;
            x_origin_reg   <= X_ORIGIN_RST;
            y_origin_reg   <= Y_ORIGIN_RST;
            pixel_step_reg <= PIXEL_STEP_RST;
            max_iter_reg   <= MAX_ITER_RST;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (cfg_wr)
            begin
                case (cfg_idx)
                    REG_X_ORIGIN:   x_origin_reg   <= pwdata;
                    REG_Y_ORIGIN:   y_origin_reg   <= pwdata;
                    REG_PIXEL_STEP: pixel_step_reg <= pwdata[STEP_W-1:0];
                    REG_MAX_ITER:   max_iter_reg   <= pwdata[CNT_W-1:0];
                    default:        max_iter_reg   <= max_iter_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg        <= col_next;
        row_reg        <= row_next;
        cr_reg         <= cr_next;
        ci_reg         <= ci_next;
        zr_reg         <= zr_next;
        zi_reg         <= zi_next;
        r2_reg         <= r2_next;
        i2_reg         <= i2_next;
        n_reg          <= n_next;
        inside_reg     <= inside_next;
        p_reg          <= p_next;
        res_count_reg  <= res_count_next;
        res_inside_reg <= res_inside_next;
    end

    `MET_ASSERT(a_busy_after_accept, clk, rst_n, (item_valid && item_ready) |=> !item_ready, "item accepted while busy")
    `MET_ASSERT(a_test_after_square, clk, rst_n, (state_reg == S_TST) |-> ($past(state_reg) == S_MII), "escape test out of sequence")
    `MET_ASSERT(a_result_from_done, clk, rst_n, $rose(res_valid) |-> ($past(state_reg) == S_DONE), "result without finished item")
    `MET_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !res_valid, "result valid during reset")

endmodule

[dv/tb.sv]
// testbench for mandelbrot_escape_time: pixel transfers in, escape counts out
// self-checking against a fixed-point escape-time predictor; needs met_pkg and the rtl
`timescale 1ns / 1ps

module tb;
    import met_pkg::*;

    localparam int     CYCLE_LIMIT  = 4_000_000;
    localparam int     PHASES       = 14;
    localparam int     PHASE_ITEMS  = 125;
    localparam longint W_MAX        = (longint'(1) << (FRAC_BITS + 3)) - 1;
    localparam longint W_MIN        = -W_MAX - 1;
    localparam longint ESCAPE_LIMIT = longint'(1) << (FRAC_BITS + 2);

    typedef struct packed {
        cnt_t count;
        logic in_set;
    } escape_result_t;

    class escape_scoreboard;
        logic [31:0]       x_origin;
        logic [31:0]       y_origin;
        logic [STEP_W-1:0] pixel_step;
        cnt_t              max_iter;
        escape_result_t    pending_results[$];
        int                errors;

        function new();
            x_origin   = X_ORIGIN_RST;
            y_origin   = Y_ORIGIN_RST;
            pixel_step = PIXEL_STEP_RST;
            max_iter   = MAX_ITER_RST;
            errors     = 0;
        endfunction

        function void write_register(reg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_X_ORIGIN:   x_origin = value;
                REG_Y_ORIGIN:   y_origin = value;
                REG_PIXEL_STEP: pixel_step = value[STEP_W-1:0];
                REG_MAX_ITER:   max_iter = value[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        static function longint clip(longint v);
            if (v > W_MAX)
                return W_MAX;
            if (v < W_MIN)
                return W_MIN;
            return v;
        endfunction

        static function longint to_fixed(longint v);
            if (FRAC_BITS >= REG_FRAC)
                return v <<< (FRAC_BITS - REG_FRAC);
            return v >>> (REG_FRAC - FRAC_BITS);
        endfunction

        // floor of the product over 2^sh, saturated
        static function longint fix_mul(longint a, longint b, int sh);
            return clip((a * b) >>> sh);
        endfunction

        function escape_result_t escape_time(idx_t col_in, idx_t row_in);
            longint         cstep, cre, cim, zre, zim, re2, im2, zprod, col_i, row_i;
            int             n;
            bit             escaped;
            escape_result_t res;
            col_i = longint'(col_in);
            row_i = longint'(row_in);
            if (col_i > IMAGE_SIZE - 1)
                col_i = IMAGE_SIZE - 1;
            if (row_i > IMAGE_SIZE - 1)
                row_i = IMAGE_SIZE - 1;
            cstep = to_fixed(longint'(pixel_step));
            cre = clip(to_fixed(longint'($signed(x_origin))) + fix_mul(cstep, col_i, 0));
            cim = clip(to_fixed(longint'($signed(y_origin))) + fix_mul(cstep, row_i, 0));
            zre = 0;
            zim = 0;
            n = 0;
            escaped = 1'b0;
            while (n < int'(max_iter) && !escaped)
            begin
                re2   = fix_mul(zre, zre, FRAC_BITS);
                im2   = fix_mul(zim, zim, FRAC_BITS);
                zprod = fix_mul(zre, zim, FRAC_BITS - 1);
                zre = clip(clip(re2 - im2) + cre);
                zim = clip(zprod + cim);
                re2 = fix_mul(zre, zre, FRAC_BITS);
                im2 = fix_mul(zim, zim, FRAC_BITS);
                if (re2 + im2 > ESCAPE_LIMIT)
                    escaped = 1'b1;
                else
                    n++;
            end
            res.count  = cnt_t'(n);
            res.in_set = (n >= int'(max_iter));
            return res;
        endfunction

        function void note_pixel(idx_t col_in, idx_t row_in);
            pending_results.push_back(escape_time(col_in, row_in));
        endfunction

        function void check_result(cnt_t count, logic in_set);
            escape_result_t exp_res;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: count %0d inside %0b", count, in_set);
                return;
            end
            exp_res = pending_results.pop_front();
            if (exp_res.count !== count || exp_res.in_set !== in_set)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected count %0d inside %0b, got count %0d inside %0b",
                             exp_res.count, exp_res.in_set, count, in_set);
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              item_valid;
    logic              item_ready;
    logic [IDX_W-1:0]  column;
    logic [IDX_W-1:0]  row;
    logic              res_valid;
    logic              res_ready;
    logic [CNT_W-1:0]  iter_count;
    logic              inside_res;

    escape_scoreboard sb;
    int               cycle_count = 0;
    int               hold_cycles = 0;
    bit               no_idle = 1'b0;

    mandelbrot_escape_time uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .column     (column),
        .row        (row),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .iter_count (iter_count),
        .inside_res (inside_res)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // transfer monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
                sb.note_pixel(column, row);
            if (res_valid && res_ready)
                sb.check_result(iter_count, inside_res);
        end
    end

    // result side back-pressure
    initial
    begin
        res_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                res_ready <= 1'b0;
                hold_cycles--;
            end
            else
                res_ready <= no_idle || ($urandom_range(99) >= 7);
        end
    end

    // called and returns at a falling edge
    task automatic send_pixel(input idx_t col_in, input idx_t row_in);
        while (!no_idle && $urandom_range(99) < 7)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        column     <= col_in;
        row        <= row_in;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.write_register(idx, value);
        @(negedge clk);
    endtask

    task automatic set_view(input logic [31:0] xo, input logic [31:0] yo,
                            input logic [31:0] step, input logic [31:0] limit);
        drain();
        apb_write(REG_X_ORIGIN, xo);
        apb_write(REG_Y_ORIGIN, yo);
        apb_write(REG_PIXEL_STEP, step);
        apb_write(REG_MAX_ITER, limit);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    function automatic idx_t pick_index();
        if ($urandom_range(7) == 0)
            return $urandom_range(1) ? idx_t'(IMAGE_SIZE - 1) : idx_t'(0);
        return idx_t'($urandom_range(IMAGE_SIZE - 1));
    endfunction

    function automatic logic [31:0] pick_edge();
        case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return 32'hE000_0000;
        endcase
    endfunction

    function automatic logic [31:0] with_junk(input cnt_t limit);
        logic [31:0] word;
        word = $urandom;
        word[CNT_W-1:0] = limit;
        return word;
    endfunction

    initial
    begin
        logic [31:0] xo, yo, step;
        cnt_t        limit;
        sb = new();
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        item_valid = 1'b0;
        column     = '0;
        row        = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset view, corners and alternating bit patterns
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'h2AA, 10'h155);
        send_pixel(10'h155, 10'h2AA);

        // zero and unit iteration limits
        set_view(32'hE000_0000, 32'hE000_0000, 32'h0010_0000, 32'd0);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd512, 10'd512);
        set_view(32'hE000_0000, 32'hE000_0000, 32'h0010_0000, 32'hFFFF_F001);
        send_pixel(10'd512, 10'd512);
        send_pixel(10'd0, 10'd0);

        // saturating point c
        set_view(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd4095);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd0, 10'd0);
        set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'd4095);
        send_pixel(10'd0, 10'd1023);

        // origin stays bounded up to the largest limit
        set_view(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'd4095);
        send_pixel(10'd0, 10'd0);

        // c = -2 sits exactly on the escape radius; then c near -1 with the smallest step
        set_view(32'hE000_0000, 32'h0000_0000, 32'h0000_0000, 32'd300);
        send_pixel(10'd1023, 10'd0);
        set_view(32'hF000_0000, 32'h0000_0000, 32'h0000_0001, 32'd100);
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph % 3)
                0:
                begin
                    xo   = 32'hE000_0000 + $urandom_range(32'h1000_0000);
                    yo   = 32'hE800_0000 + $urandom_range(32'h0800_0000);
                    step = {1'($urandom_range(1)),
                            31'($urandom_range(32'h0010_0000, 32'h0004_0000))};
                end
                1:
                begin
                    xo   = $urandom;
                    yo   = $urandom;
                    step = $urandom;
                end
                default:
                begin
                    xo = pick_edge();
                    yo = pick_edge();
                    case ($urandom_range(3))
                        0:       step = 32'h0000_0000;
                        1:       step = 32'h7FFF_FFFF;
                        2:       step = 32'hFFFF_FFFF;
                        default: step = 32'h0000_0001;
                    endcase
                end
            endcase
            limit = (ph == 3) ? cnt_t'(255) : cnt_t'($urandom_range(40));
            set_view(xo, yo, step, with_junk(limit));
            if (ph == 1)
                hold_cycles = 3000;
            no_idle = (ph == 6);
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_pixel(pick_index(), pick_index());
        end
        drain();
        no_idle = 1'b0;

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
